FILE: rtl/core/arp_pkg.sv
package arp_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    localparam logic [15:0] HTYPE_ETH    = 16'h0001;
    localparam logic [15:0] PTYPE_IP4    = 16'h0800;
    localparam logic [15:0] OPER_WHO_HAS = 16'h0001;
    localparam logic [15:0] OPER_IS_AT   = 16'h0002;
    localparam logic [47:0] NULL_MAC     = 48'h0;
    localparam logic [10:0] ARP_MIN_LEN  = 11'd28;

    localparam logic CMD_RESOLVE = 1'b0;
    localparam logic CMD_PACKET  = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_PENDING  = 2'd1,
        ST_RESOLVED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_REPLY   = 2'd2
    } action_t;

    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [47:0] hit_mac;
        logic        match;
        idx_t        match_idx;
        logic        free;
        idx_t        free_idx;
    } scan_t;

    typedef struct packed {
        logic        en;
        idx_t        idx;
        status_t     status;
        logic [31:0] ip;
        logic [47:0] mac;
    } wr_t;

endpackage

FILE: rtl/core/arp_item_if.sv
interface arp_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] query_ip;
    logic [10:0] pkt_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] op_code;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [31:0] dst_ip;

    modport source (
        output valid, cmd, query_ip, pkt_len, hw_type, proto_type, op_code,
               src_ip, src_mac, dst_ip,
        input  ready
    );

    modport sink (
        input  valid, cmd, query_ip, pkt_len, hw_type, proto_type, op_code,
               src_ip, src_mac, dst_ip,
        output ready
    );
endinterface

FILE: rtl/core/arp_result_if.sv
interface arp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        found;
    logic        dropped;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;

    modport source (
        output valid, action, found, dropped, peer_mac, peer_ip,
        input  ready
    );

    modport sink (
        input  valid, action, found, dropped, peer_mac, peer_ip,
        output ready
    );
endinterface

FILE: rtl/core/arp_cell.sv
module arp_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  arp_pkg::idx_t  cell_idx,
    input  logic [31:0]    key_ip,
    input  arp_pkg::scan_t carry_in,
    output arp_pkg::scan_t carry_out,
    input  arp_pkg::wr_t   wr
);
    import arp_pkg::*;

    status_t     status_reg;
    status_t     status_next;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    scan_t       carry_reg;
    scan_t       carry_next;
    logic        sel;
    logic        ip_eq;

    assign sel   = wr.en && (wr.idx == cell_idx);
    assign ip_eq = (ip_reg == key_ip);

    always_comb
    begin
        status_next = status_reg;
        if (sel)
        begin
            status_next = wr.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_FREE;
        end
        else
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            ip_reg  <= wr.ip;
            mac_reg <= wr.mac;
        end
    end

    // add this entry's view to the record and pass it on
    always_comb
    begin
        carry_next = carry_in;
        if (carry_in.valid)
        begin
            if (!carry_in.hit && status_reg == ST_RESOLVED && ip_eq)
            begin
                carry_next.hit     = 1'b1;
                carry_next.hit_mac = mac_reg;
            end
            if (!carry_in.match && status_reg != ST_FREE && ip_eq)
            begin
                carry_next.match     = 1'b1;
                carry_next.match_idx = cell_idx;
            end
            if (!carry_in.free && status_reg == ST_FREE)
            begin
                carry_next.free     = 1'b1;
                carry_next.free_idx = cell_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    assign carry_out = carry_reg;

endmodule

FILE: rtl/core/arp_cache_and_responder.sv
// Channel  Dir  Payload                                                   Transfer
// item     in   cmd query_ip pkt_len hw_type proto_type op_code            valid & ready
//               src_ip src_mac dst_ip
// result   out  action found dropped peer_mac peer_ip                      valid & ready
// cfg      in   cfg_idx cfg_data                                          cfg_we
//
// One item at a time: after the transfer, the search record walks the row of cache cells,
// one cell a cycle. Input ready returns the cycle after the commit.
// The result waits in an output register; the next item is taken while it waits.
// A waiting result stalls the commit of the following item only.
// rst_n (asynchronous) frees every entry and clears own_ip and own_mac.
module arp_cache_and_responder (
    input  logic                               clk,
    input  logic                               rst_n,
    arp_item_if.sink                           item,
    arp_result_if.source                       result,
    input  logic                               cfg_we,
    input  logic [arp_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [arp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import arp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_START  = 4'b0010,
        S_SCAN   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t      state_reg;
    state_t      state_next;

    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;

    logic        cmd_reg;
    logic [31:0] key_ip_reg;
    logic [47:0] mac_reg;
    logic        drop_reg;
    logic        reply_reg;

    scan_t       res_reg;
    scan_t       chain_head;
    scan_t       chain [0:CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] chain_valid;

    wr_t         wr;
    logic        item_xfer;
    logic        slot_free;
    logic        commit;

    logic        out_valid_reg;
    logic [1:0]  action_reg;
    logic        found_reg;
    logic        dropped_reg;
    logic [47:0] peer_mac_reg;
    logic [31:0] peer_ip_reg;

    action_t     action_next;
    logic        found_next;
    logic        dropped_next;
    logic [47:0] peer_mac_next;
    logic [31:0] peer_ip_next;

    assign item.ready = (state_reg == S_IDLE);
    assign item_xfer  = item.valid && item.ready;
    assign slot_free  = !out_valid_reg || result.ready;
    assign commit     = (state_reg == S_COMMIT) && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                CFG_OWN_MAC: own_mac_reg <= cfg_data[47:0];
                default:     ;
            endcase
        end
    end

    // hold the item
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            cmd_reg    <= item.cmd;
            key_ip_reg <= (item.cmd == CMD_RESOLVE) ? item.query_ip : item.src_ip;
            mac_reg    <= item.src_mac;
            drop_reg   <= (item.cmd == CMD_PACKET)
                          && ((item.pkt_len < ARP_MIN_LEN)
                              || (item.hw_type != HTYPE_ETH)
                              || (item.proto_type != PTYPE_IP4));
            reply_reg  <= (item.op_code == OPER_WHO_HAS)
                          && (item.dst_ip == own_ip_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (chain[CACHE_ENTRIES].valid)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        chain_head       = '0;
        chain_head.valid = (state_reg == S_START);
    end

    assign chain[0] = chain_head;

    genvar g;
    generate
        for (g = 0; g < CACHE_ENTRIES; g++)
        begin : g_cell
            arp_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (IDX_W'(g)),
                .key_ip    (key_ip_reg),
                .carry_in  (chain[g]),
                .carry_out (chain[g+1]),
                .wr        (wr)
            );
            assign chain_valid[g] = chain[g+1].valid;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && chain[CACHE_ENTRIES].valid)
        begin
            res_reg <= chain[CACHE_ENTRIES];
        end
    end

    always_comb
    begin
        wr            = '0;
        wr.ip         = key_ip_reg;
        action_next   = ACT_NONE;
        found_next    = 1'b0;
        dropped_next  = 1'b0;
        peer_mac_next = NULL_MAC;
        peer_ip_next  = '0;
        if (cmd_reg == CMD_RESOLVE)
        begin
            if (res_reg.hit)
            begin
                found_next    = 1'b1;
                peer_mac_next = res_reg.hit_mac;
            end
            else
            begin
                wr.en        = commit && res_reg.free;
                wr.idx       = res_reg.free_idx;
                wr.status    = ST_PENDING;
                wr.mac       = NULL_MAC;
                action_next  = ACT_REQUEST;
                peer_ip_next = key_ip_reg;
            end
        end
        else if (drop_reg)
        begin
            dropped_next = 1'b1;
        end
        else
        begin
            // learn: refresh a live entry, else take a free one, else overwrite the first
            wr.en     = commit;
            wr.status = ST_RESOLVED;
            wr.mac    = mac_reg;
            if (res_reg.match)
            begin
                wr.idx = res_reg.match_idx;
            end
            else if (res_reg.free)
            begin
                wr.idx = res_reg.free_idx;
            end
            else
            begin
                wr.idx = '0;
            end
            if (reply_reg)
            begin
                action_next   = ACT_REPLY;
                peer_mac_next = mac_reg;
                peer_ip_next  = key_ip_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            action_reg   <= action_next;
            found_reg    <= found_next;
            dropped_reg  <= dropped_next;
            peer_mac_reg <= peer_mac_next;
            peer_ip_reg  <= peer_ip_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.action   = action_reg;
    assign result.found    = found_reg;
    assign result.dropped  = dropped_reg;
    assign result.peer_mac = peer_mac_reg;
    assign result.peer_ip  = peer_ip_reg;

    a_one_record: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one search record in the cell row");

    a_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[CACHE_ENTRIES].valid |-> (state_reg == S_SCAN))
        else $error("search record left the row outside the scan");

    a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> ((state_reg == S_COMMIT) && (!out_valid_reg || result.ready)))
        else $error("cache write outside a commit");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_COMMIT))
        else $error("result raised without a commit");

endmodule

FILE: tb/arp_cache_and_responder_tb.sv
`timescale 1ns / 1ps

module arp_cache_and_responder_tb;
    import arp_pkg::*;

    typedef struct packed {
        logic        cmd;
        logic [31:0] query_ip;
        logic [10:0] pkt_len;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] op_code;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
        logic [31:0] dst_ip;
    } arp_item_t;

    typedef struct packed {
        action_t     action;
        logic        found;
        logic        dropped;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
    } arp_answer_t;

    localparam int POOL_SIZE = 24;
    localparam int SETTLE_CYCLES = CACHE_ENTRIES + 3 + 8;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    arp_item_if   item_ch ();
    arp_result_if result_ch ();

    arp_cache_and_responder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    status_t     slot_state [CACHE_ENTRIES];
    logic [31:0] slot_ip    [CACHE_ENTRIES];
    logic [47:0] slot_mac   [CACHE_ENTRIES];
    logic [31:0] cur_own_ip;
    logic [47:0] cur_own_mac;

    arp_answer_t awaited_answers [$];
    logic [31:0] ip_pool [POOL_SIZE];

    int  fail_count;
    int  items_sent;
    int  hit_count;
    int  request_count;
    int  reply_count;
    int  drop_count;
    int  long_hold;
    bit  idling_on;

    always #2 clk = ~clk;

    function automatic int first_free_slot();
        int i;
        for (i = 0; i < CACHE_ENTRIES; i++)
            if (slot_state[i] == ST_FREE)
                return i;
        return -1;
    endfunction

    function automatic arp_answer_t predict_answer(input arp_item_t it);
        arp_answer_t ans;
        int          slot;
        int          i;
        ans.action   = ACT_NONE;
        ans.found    = 1'b0;
        ans.dropped  = 1'b0;
        ans.peer_mac = NULL_MAC;
        ans.peer_ip  = 32'h0;
        slot = -1;
        if (it.cmd == CMD_RESOLVE) begin
            for (i = 0; i < CACHE_ENTRIES; i++)
                if (slot < 0 && slot_state[i] == ST_RESOLVED && slot_ip[i] == it.query_ip)
                    slot = i;
            if (slot >= 0) begin
                ans.found    = 1'b1;
                ans.peer_mac = slot_mac[slot];
                hit_count++;
            end
            else begin
                slot = first_free_slot();
                if (slot >= 0) begin
                    slot_state[slot] = ST_PENDING;
                    slot_ip[slot]    = it.query_ip;
                    slot_mac[slot]   = NULL_MAC;
                end
                ans.action  = ACT_REQUEST;
                ans.peer_ip = it.query_ip;
                request_count++;
            end
        end
        else if (it.pkt_len < ARP_MIN_LEN || it.hw_type != HTYPE_ETH
                 || it.proto_type != PTYPE_IP4) begin
            ans.dropped = 1'b1;
            drop_count++;
        end
        else begin
            for (i = 0; i < CACHE_ENTRIES; i++)
                if (slot < 0 && slot_state[i] != ST_FREE && slot_ip[i] == it.src_ip)
                    slot = i;
            if (slot < 0)
                slot = first_free_slot();
            if (slot < 0)
                slot = 0;
            slot_state[slot] = ST_RESOLVED;
            slot_ip[slot]    = it.src_ip;
            slot_mac[slot]   = it.src_mac;
            if (it.op_code == OPER_WHO_HAS && it.dst_ip == cur_own_ip) begin
                ans.action   = ACT_REPLY;
                ans.peer_mac = it.src_mac;
                ans.peer_ip  = it.src_ip;
                reply_count++;
            end
        end
        return ans;
    endfunction

    function automatic arp_item_t make_query(input logic [31:0] ip);
        arp_item_t it;
        it          = '0;
        it.cmd      = CMD_RESOLVE;
        it.query_ip = ip;
        return it;
    endfunction

    function automatic arp_item_t make_packet(input logic [10:0] len, input logic [15:0] hw,
                                              input logic [15:0] pt, input logic [15:0] op,
                                              input logic [31:0] sip, input logic [47:0] smac,
                                              input logic [31:0] tip);
        arp_item_t it;
        it            = '0;
        it.cmd        = CMD_PACKET;
        it.pkt_len    = len;
        it.hw_type    = hw;
        it.proto_type = pt;
        it.op_code    = op;
        it.src_ip     = sip;
        it.src_mac    = smac;
        it.dst_ip     = tip;
        return it;
    endfunction

    function automatic logic [31:0] pick_ip();
        if ($urandom_range(0, 3) != 0)
            return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic arp_item_t random_item();
        arp_item_t it;
        int        r;
        it.cmd        = 1'($urandom_range(0, 1));
        it.query_ip   = pick_ip();
        it.pkt_len    = 11'($urandom_range(28, 2047));
        if ($urandom_range(0, 3) == 0)
            it.pkt_len = 11'($urandom_range(28, 64));
        it.hw_type    = HTYPE_ETH;
        it.proto_type = PTYPE_IP4;
        r = $urandom_range(0, 99);
        if (r < 45)
            it.op_code = OPER_WHO_HAS;
        else if (r < 80)
            it.op_code = OPER_IS_AT;
        else
            it.op_code = 16'($urandom);
        it.src_ip     = pick_ip();
        it.src_mac    = {16'($urandom), 32'($urandom)};
        it.dst_ip     = ($urandom_range(0, 9) < 4) ? cur_own_ip : pick_ip();
        case ($urandom_range(0, 19))
            0: it.pkt_len    = 11'($urandom_range(0, 27));
            1: it.hw_type    = 16'($urandom);
            2: it.proto_type = 16'($urandom);
            3:
            begin
                it.pkt_len    = 11'($urandom);
                it.hw_type    = 16'($urandom);
                it.proto_type = 16'($urandom);
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_item(input arp_item_t it);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= it.cmd;
        item_ch.query_ip   <= it.query_ip;
        item_ch.pkt_len    <= it.pkt_len;
        item_ch.hw_type    <= it.hw_type;
        item_ch.proto_type <= it.proto_type;
        item_ch.op_code    <= it.op_code;
        item_ch.src_ip     <= it.src_ip;
        item_ch.src_mac    <= it.src_mac;
        item_ch.dst_ip     <= it.dst_ip;
        do @(posedge clk); while (!item_ch.ready);
        awaited_answers.push_back(predict_answer(it));
        items_sent++;
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (awaited_answers.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_OWN_IP)
            cur_own_ip = value[31:0];
        else
            cur_own_mac = value;
        @(posedge clk);
    endtask

    task automatic check_answer();
        arp_answer_t want;
        if (awaited_answers.size() == 0)
        begin
            $error("result transfer with no expectation waiting");
            fail_count++;
        end
        else
        begin
            want = awaited_answers.pop_front();
            if (result_ch.action !== want.action)
            begin
                $error("action: expected %0d, actual %0d", want.action, result_ch.action);
                fail_count++;
            end
            if (result_ch.found !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, result_ch.found);
                fail_count++;
            end
            if (result_ch.dropped !== want.dropped)
            begin
                $error("dropped: expected %0d, actual %0d", want.dropped, result_ch.dropped);
                fail_count++;
            end
            if (result_ch.peer_mac !== want.peer_mac)
            begin
                $error("peer_mac: expected %h, actual %h", want.peer_mac, result_ch.peer_mac);
                fail_count++;
            end
            if (result_ch.peer_ip !== want.peer_ip)
            begin
                $error("peer_ip: expected %h, actual %h", want.peer_ip, result_ch.peer_ip);
                fail_count++;
            end
        end
    endtask

    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                check_answer();
            if (long_hold > 0)
            begin
                stall_left = long_hold;
                long_hold  = 0;
            end
            else if (stall_left == 0 && idling_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 7);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic test_resolve_paths();
        send_item(make_query(32'h0A00_0001));
        send_item(make_query(32'h0A00_0001));
        send_item(make_packet(11'd28, HTYPE_ETH, PTYPE_IP4, OPER_IS_AT,
                              32'h0A00_0001, 48'h0200_1122_3344, 32'h0A00_00FE));
        send_item(make_query(32'h0A00_0001));
    endtask

    task automatic test_drop_filters();
        send_item(make_packet(11'd27, HTYPE_ETH, PTYPE_IP4, OPER_WHO_HAS,
                              32'h0A00_0002, 48'h0200_0000_0002, cur_own_ip));
        send_item(make_packet(11'd0, HTYPE_ETH, PTYPE_IP4, OPER_WHO_HAS,
                              32'h0A00_0002, 48'h0200_0000_0002, cur_own_ip));
        send_item(make_packet(11'd64, 16'hFFFF, PTYPE_IP4, OPER_WHO_HAS,
                              32'h0A00_0002, 48'h0200_0000_0002, cur_own_ip));
        send_item(make_packet(11'd2047, HTYPE_ETH, 16'h0000, OPER_IS_AT,
                              32'h0A00_0002, 48'h0200_0000_0002, cur_own_ip));
    endtask

    task automatic test_responses();
        send_item(make_packet(11'd28, HTYPE_ETH, PTYPE_IP4, OPER_WHO_HAS,
                              32'h0A00_0003, 48'hFEDC_BA98_7654, cur_own_ip));
        send_item(make_packet(11'd2047, HTYPE_ETH, PTYPE_IP4, OPER_WHO_HAS,
                              32'h0A00_0004, 48'h0200_0000_0004, ~cur_own_ip));
        send_item(make_packet(11'd60, HTYPE_ETH, PTYPE_IP4, 16'hFFFF,
                              32'h0000_0000, 48'h0, cur_own_ip));
        send_item(make_packet(11'd46, HTYPE_ETH, PTYPE_IP4, 16'h0000,
                              32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_packet(11'd28, HTYPE_ETH, PTYPE_IP4, OPER_IS_AT,
                              32'h0A00_0005, 48'h0200_0000_0005, cur_own_ip));
        send_item(make_query(32'h0000_0000));
        send_item(make_query(32'hFFFF_FFFF));
    endtask

    task automatic test_full_cache();
        int n;
        n = 0;
        while (first_free_slot() >= 0)
        begin
            send_item(make_query(32'hAC10_0000 + 32'(n)));
            n++;
        end
        send_item(make_query(32'hAC10_FFFF));
        send_item(make_packet(11'd28, HTYPE_ETH, PTYPE_IP4, OPER_IS_AT,
                              32'h0A0B_0C0D, 48'h0200_0B0C_0D0E, 32'h0A00_0099));
        send_item(make_query(32'h0A00_0001));
        send_item(make_query(32'h0A0B_0C0D));
    endtask

    task automatic test_random_traffic(input int count);
        int k;
        for (k = 0; k < count; k++)
            send_item(random_item());
    endtask

    task automatic test_backpressure();
        int k;
        bit keep;
        keep      = idling_on;
        idling_on = 1'b0;
        long_hold = 150;
        for (k = 0; k < 24; k++)
            send_item(random_item());
        idling_on = keep;
        wait_drained();
    endtask

    task automatic test_sender_pause();
        test_random_traffic(30);
        wait_drained();
        test_random_traffic(30);
        wait_drained();
    endtask

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int i;
        rst_n      = 1'b0;
        fail_count = 0;
        items_sent = 0;
        hit_count  = 0;
        request_count = 0;
        reply_count   = 0;
        drop_count    = 0;
        long_hold  = 0;
        idling_on  = 1'b1;
        cur_own_ip  = 32'h0;
        cur_own_mac = 48'h0;
        for (i = 0; i < CACHE_ENTRIES; i++)
        begin
            slot_state[i] = ST_FREE;
            slot_ip[i]    = 32'h0;
            slot_mac[i]   = 48'h0;
        end
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        for (i = 2; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_OWN_IP;
        cfg_data <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.cmd        <= CMD_RESOLVE;
        item_ch.query_ip   <= '0;
        item_ch.pkt_len    <= '0;
        item_ch.hw_type    <= '0;
        item_ch.proto_type <= '0;
        item_ch.op_code    <= '0;
        item_ch.src_ip     <= '0;
        item_ch.src_mac    <= '0;
        item_ch.dst_ip     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_OWN_IP, 48'h0000_C0A8_0164);
        write_reg(CFG_OWN_MAC, {16'($urandom), 32'($urandom)});
        test_resolve_paths();
        test_drop_filters();
        test_responses();
        test_full_cache();
        wait_drained();

        write_reg(CFG_OWN_IP, 48'h0000_FFFF_FFFF);
        write_reg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        test_random_traffic(380);
        test_backpressure();

        write_reg(CFG_OWN_IP, 48'h0);
        write_reg(CFG_OWN_MAC, 48'h0);
        test_random_traffic(380);
        test_sender_pause();

        write_reg(CFG_OWN_IP, {16'h0, ip_pool[$urandom_range(2, POOL_SIZE - 1)]});
        write_reg(CFG_OWN_MAC, {16'($urandom), 32'($urandom)});
        test_random_traffic(380);
        wait_drained();

        idling_on = 1'b0;
        write_reg(CFG_OWN_IP, {16'h0, ip_pool[$urandom_range(2, POOL_SIZE - 1)]});
        test_random_traffic(290);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d transfers under five address settings, with long output stalls.",
                 items_sent);
        $display("Cache hits %0d, broadcast requests %0d, unicast replies %0d, drops %0d.",
                 hit_count, request_count, reply_count, drop_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
